// ===== rtl/lcab_pkg.sv =====
// package for the binary-lifting lowest common ancestor engine
package lcab_pkg;
    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 10;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int ANC_W       = NODE_W + 1;
    localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int DEPTH_W     = LIFT_LEVELS;
    localparam int TBL_DEPTH   = MAX_NODES * LIFT_LEVELS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int CNT_W       = 11;
    localparam logic [ANC_W-1:0] NONE_CODE = ANC_W'(MAX_NODES);

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BUILD = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B0_RD, ST_B0_WT, ST_B0_WR,
        ST_BL_RD, ST_BL_WT, ST_BL_RD2, ST_BL_WT2, ST_BL_WR,
        ST_BD_RD, ST_BD_WT, ST_BD_WR,
        ST_Q_RD, ST_Q_WT, ST_Q_CMP,
        ST_QK_RD, ST_QK_WT,
        ST_QJ_RDU, ST_QJ_WTU, ST_QJ_RDV, ST_QJ_WTV,
        ST_QF_RD, ST_QF_WT,
        ST_OUT
    } state_t;

    function automatic logic [TBL_AW-1:0] tix(input logic [NODE_W-1:0] node,
                                              input logic [LVL_W-1:0] lvl);
        tix = TBL_AW'(node * LIFT_LEVELS + lvl);
    endfunction
endpackage

// ===== rtl/lca_binary_lifting.sv =====
// binary-lifting lowest common ancestor engine, top level
//
// channels: s_ input beats carry load, build and query requests; m_ beats
// carry one result per query; cfg_ writes node_count (only while idle).
// load (req_type 0): writes one parent into level 0 of the ancestor table in
//   the accept cycle; the next beat can follow at once.
// build (req_type 1): normalizes level 0, fills levels 1..LIFT_LEVELS-1 and
//   derives depths; its table accesses share the single port of the ancestor
//   table memory.
// query (req_type 2): depth reads, then up to LIFT_LEVELS single lifts and
//   LIFT_LEVELS joint lifts with two table reads each; the joint lifts are
//   skipped when the single lifts meet the other node, and an out of range
//   node goes straight to the result.
// req_type 3 is dropped. one item is in work at a time; s_tready is high only
//   in the idle state.
// reset: control state clears, node_count returns to 1; table and depth
//   memories are undefined until loaded and built.
// stall: a finished result waits in the output register while m_tready is
//   low; the engine holds until the beat is taken.
module lca_binary_lifting
    import lcab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[1:0], child_node[11:2], parent_node[21:12], first_node[31:22],
    // second_node[41:32], zero fill [47:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // common_ancestor[9:0], bad_query[10], zero fill [15:11]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // node_count[10:0]
);
    // memories
    logic [ANC_W-1:0]   tbl_mem [TBL_DEPTH];
    logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
    logic [TBL_AW-1:0]  t_addr;
    logic               t_we;
    logic [ANC_W-1:0]   t_wdata, t_rdata;
    logic [NODE_W-1:0]  d_addr;
    logic               d_we;
    logic [DEPTH_W-1:0] d_wdata, d_rdata;

    always_ff @(posedge aclk) begin
        if (t_we) tbl_mem[t_addr] <= t_wdata;
        t_rdata <= tbl_mem[t_addr];
    end
    always_ff @(posedge aclk) begin
        if (d_we) dep_mem[d_addr] <= d_wdata;
        d_rdata <= dep_mem[d_addr];
    end

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   ncnt_reg;
    logic [NODE_W:0]    used;   // effective count, fits MAX_NODES
    logic [NODE_W-1:0]  i_reg, i_next;
    logic [LVL_W-1:0]   l_reg, l_next;
    logic [NODE_W-1:0]  u_reg, u_next, v_reg, v_next;
    logic [ANC_W-1:0]   au_reg, au_next;
    logic [DEPTH_W-1:0] k_reg, k_next, du_reg, du_next, dacc_reg, dacc_next;
    logic [NODE_W-1:0]  res_reg, res_next;
    logic               bad_reg, bad_next;
    logic               mv_reg, mv_next;

    logic [1:0]        in_req;
    logic [NODE_W-1:0] in_child, in_par, in_a, in_b;
    assign in_req   = s_tdata[1:0];
    assign in_child = s_tdata[11:2];
    assign in_par   = s_tdata[21:12];
    assign in_a     = s_tdata[31:22];
    assign in_b     = s_tdata[41:32];

    assign used = (ncnt_reg < CNT_W'(MAX_NODES)) ? (NODE_W+1)'(ncnt_reg)
                                                : (NODE_W+1)'(MAX_NODES);

    logic last_node, rd_none;
    assign last_node = ({1'b0, i_reg} == used - 1'b1);
    assign rd_none   = (t_rdata >= NONE_CODE);
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LIFT_LEVELS - 1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {5'd0, bad_reg, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ncnt_reg  <= CNT_W'(1);
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (cfg_valid && cfg_ready) ncnt_reg <= cfg_data[CNT_W-1:0];
        end
    end
    always_ff @(posedge aclk) begin
        i_reg <= i_next; l_reg <= l_next; u_reg <= u_next; v_reg <= v_next;
        au_reg <= au_next; k_reg <= k_next; du_reg <= du_next;
        dacc_reg <= dacc_next; res_reg <= res_next; bad_reg <= bad_next;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        i_next = i_reg; l_next = l_reg; u_next = u_reg; v_next = v_reg;
        au_next = au_reg; k_next = k_reg; du_next = du_reg;
        dacc_next = dacc_reg; res_next = res_reg; bad_next = bad_reg;
        mv_next = mv_reg;
        t_addr = tix(u_reg, l_reg); t_we = 1'b0; t_wdata = '0;
        d_addr = u_reg; d_we = 1'b0; d_wdata = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (req_t'(in_req))
                        REQ_LOAD: begin
                            t_addr  = tix(in_child, '0);
                            t_we    = (in_child != '0);
                            t_wdata = {1'b0, in_par};
                        end
                        REQ_BUILD: begin
                            i_next = '0;
                            state_next = ST_B0_RD;
                        end
                        REQ_QUERY: begin
                            u_next = in_a; v_next = in_b;
                            res_next = '0;
                            if ({1'b0, in_a} >= used || {1'b0, in_b} >= used) begin
                                bad_next = 1'b1;
                                state_next = ST_OUT;
                                mv_next = 1'b1;
                            end else begin
                                bad_next = 1'b0;
                                state_next = ST_Q_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // level 0 normalize
            ST_B0_RD: begin t_addr = tix(i_reg, '0); state_next = ST_B0_WT; end
            ST_B0_WT: begin t_addr = tix(i_reg, '0); state_next = ST_B0_WR; end
            ST_B0_WR: begin
                t_addr = tix(i_reg, '0);
                if (i_reg == '0 || t_rdata >= ANC_W'(used)) begin
                    t_we = 1'b1; t_wdata = NONE_CODE;
                end
                if (last_node) begin
                    if (LIFT_LEVELS > 1) begin
                        l_next = LVL_W'(1); i_next = '0; state_next = ST_BL_RD;
                    end else begin
                        i_next = '0; u_next = '0; l_next = TOP_LVL; dacc_next = '0;
                        state_next = ST_BD_RD;
                    end
                end else begin
                    i_next = i_reg + 1'b1; state_next = ST_B0_RD;
                end
            end
            // level l from level l-1
            ST_BL_RD: begin t_addr = tix(i_reg, l_reg - 1'b1); state_next = ST_BL_WT; end
            ST_BL_WT: begin
                au_next = t_rdata;
                state_next = ST_BL_RD2;
            end
            ST_BL_RD2: begin
                if (au_reg >= ANC_W'(used)) begin
                    state_next = ST_BL_WR;
                end else begin
                    t_addr = tix(au_reg[NODE_W-1:0], l_reg - 1'b1);
                    state_next = ST_BL_WT2;
                end
            end
            ST_BL_WT2: begin
                au_next = rd_none ? NONE_CODE : t_rdata;
                state_next = ST_BL_WR;
            end
            ST_BL_WR: begin
                t_addr = tix(i_reg, l_reg); t_we = 1'b1;
                t_wdata = (au_reg >= ANC_W'(used) && au_reg != NONE_CODE
                           && au_reg < NONE_CODE) ? NONE_CODE : au_reg;
                if (au_reg >= ANC_W'(used)) t_wdata = NONE_CODE;
                if (last_node) begin
                    i_next = '0;
                    if (l_reg == TOP_LVL) begin
                        u_next = '0; l_next = TOP_LVL; dacc_next = '0;
                        state_next = ST_BD_RD;
                    end else begin
                        l_next = l_reg + 1'b1; state_next = ST_BL_RD;
                    end
                end else begin
                    i_next = i_reg + 1'b1; state_next = ST_BL_RD;
                end
            end
            // depth walk, x in u_reg
            ST_BD_RD: begin t_addr = tix(u_reg, l_reg); state_next = ST_BD_WT; end
            ST_BD_WT: state_next = ST_BD_WR;
            ST_BD_WR: begin
                logic [DEPTH_W-1:0] dn;
                dn = dacc_reg;
                if (!rd_none) begin
                    u_next = t_rdata[NODE_W-1:0];
                    dn = dacc_reg | (DEPTH_W'(1) << l_reg);
                end
                dacc_next = dn;
                if (l_reg == '0) begin
                    d_addr = i_reg; d_we = 1'b1; d_wdata = dn;
                    if (last_node) state_next = ST_IDLE;
                    else begin
                        i_next = i_reg + 1'b1; u_next = i_reg + 1'b1;
                        l_next = TOP_LVL; dacc_next = '0; state_next = ST_BD_RD;
                    end
                end else begin
                    l_next = l_reg - 1'b1; state_next = ST_BD_RD;
                end
            end
            // query: depths
            ST_Q_RD: begin d_addr = u_reg; state_next = ST_Q_WT; end
            ST_Q_WT: begin
                d_addr = v_reg; du_next = d_rdata; state_next = ST_Q_CMP;
            end
            ST_Q_CMP: begin
                if (du_reg < d_rdata) begin
                    u_next = v_reg; v_next = u_reg; k_next = d_rdata - du_reg;
                end else k_next = du_reg - d_rdata;
                l_next = TOP_LVL; state_next = ST_QK_RD;
            end
            ST_QK_RD: begin
                if (k_reg[l_reg]) begin
                    t_addr = tix(u_reg, l_reg); state_next = ST_QK_WT;
                end else if (l_reg == '0) begin
                    l_next = TOP_LVL; state_next = ST_QJ_RDU;
                    if (u_reg == v_reg) begin
                        res_next = u_reg; mv_next = 1'b1; state_next = ST_OUT;
                    end
                end else l_next = l_reg - 1'b1;
            end
            ST_QK_WT: begin
                logic [NODE_W-1:0] un;
                un = rd_none ? u_reg : t_rdata[NODE_W-1:0];
                u_next = un;
                if (l_reg == '0) begin
                    l_next = TOP_LVL; state_next = ST_QJ_RDU;
                    if (un == v_reg) begin
                        res_next = un; mv_next = 1'b1; state_next = ST_OUT;
                    end
                end else begin
                    l_next = l_reg - 1'b1; state_next = ST_QK_RD;
                end
            end
            ST_QJ_RDU: begin t_addr = tix(u_reg, l_reg); state_next = ST_QJ_WTU; end
            ST_QJ_WTU: begin
                au_next = rd_none ? NONE_CODE : t_rdata; state_next = ST_QJ_RDV;
            end
            ST_QJ_RDV: begin t_addr = tix(v_reg, l_reg); state_next = ST_QJ_WTV; end
            ST_QJ_WTV: begin
                if (!rd_none && au_reg != NONE_CODE && au_reg != t_rdata) begin
                    u_next = au_reg[NODE_W-1:0]; v_next = t_rdata[NODE_W-1:0];
                end
                if (l_reg == '0) state_next = ST_QF_RD;
                else begin l_next = l_reg - 1'b1; state_next = ST_QJ_RDU; end
            end
            ST_QF_RD: begin t_addr = tix(u_reg, '0); state_next = ST_QF_WT; end
            ST_QF_WT: begin
                res_next = rd_none ? '0 : t_rdata[NODE_W-1:0];
                mv_next = 1'b1; state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin mv_next = 1'b0; state_next = ST_IDLE; end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_busy_in: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[9:0] == '0)
        else $error("bad query with nonzero ancestor");
`endif
endmodule
